FILE: rtl/core/sgm_pkg.sv
// Shared types, constants and state codes of the stereo gain mixer with soft clip.
`default_nettype none
package sgm_pkg;

	// Field widths
	localparam int GAIN_W             = 16;
	localparam int GAIN_FRAC_BITS_DEF = 15;
	localparam int SAMPLE_W           = 16;
	localparam int PEAK_W             = 15;
	localparam int XQ_W               = 18;
	localparam int X2_W               = 36;
	localparam int DEN_W              = 40;
	localparam int NUM_W              = 56;
	localparam int QUO_W              = 26;
	localparam int YQ_W               = 25;
	localparam int CNT_W              = 5;
	localparam int QDEPTH             = 2;
	localparam int QPTR_W             = 1;

	// Rational tanh constants in Q32 and Q24
	localparam logic [DEN_W-1:0]  K27     = DEN_W'(27) << 32;
	localparam logic [YQ_W-1:0]   YQ_ONE  = YQ_W'(1) << 24;
	localparam logic [PEAK_W-1:0] MAG_MAX = {PEAK_W{1'b1}};

	// Configuration register indexes
	localparam logic REG_MIC_GAIN = 1'b0;
	localparam logic REG_SYS_GAIN = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mic_left;
		logic signed [SAMPLE_W-1:0] mic_right;
		logic signed [SAMPLE_W-1:0] sys_left;
		logic signed [SAMPLE_W-1:0] sys_right;
		logic                       mic_present;
		logic                       sys_present;
		logic                       last_in_block;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic [PEAK_W-1:0]          block_peak_left;
		logic [PEAK_W-1:0]          block_peak_right;
		logic                       frame_last;
	} out_t;

	// Classified frame handed from front to back
	typedef struct packed {
		logic [XQ_W-1:0] xq_l;
		logic [XQ_W-1:0] xq_r;
		logic            clip_l;
		logic            clip_r;
		logic            neg_l;
		logic            neg_r;
		logic            last;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_NUM,
		ST_DIV,
		ST_SCALE,
		ST_FIN
	} bstate_t;

endpackage
`default_nettype wire

FILE: rtl/core/sgm_front.sv
// Front end: accepts frames, applies gains, sums channels and classifies the mix.
`default_nettype none
module sgm_front #(
	parameter int GAIN_FRAC_BITS = sgm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sgm_pkg::in_t                frame,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [sgm_pkg::GAIN_W-1:0]  mic_gain,
	input  wire logic [sgm_pkg::GAIN_W-1:0]  sys_gain,
	input  wire sgm_pkg::qstat_t             qstat,
	output logic                             q_push,
	output sgm_pkg::job_t                    q_data
);
	localparam int F       = GAIN_FRAC_BITS + 15;
	localparam int SHIFT   = F - 16;
	localparam int PROD_W  = 33;
	localparam int SUM_W   = 34;
	localparam logic [SUM_W-1:0] CLIP_LIM = SUM_W'(3) << F;
	localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] mic_l_s1, mic_r_s1, sys_l_s1, sys_r_s1;
	logic                     last_s1;
	logic                     load;
	logic signed [SUM_W-1:0]  sum_l, sum_r;
	logic [SUM_W-1:0]         mag_l, mag_r;

	assign full   = valid_s1 && qstat.full;
	assign load   = push && !full;
	assign q_push = valid_s1 && !qstat.full;

	// Hold the scaled samples; drop absent sources as silence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mic_l_s1 <= frame.mic_present ?
				frame.mic_left * $signed({1'b0, mic_gain}) : PROD_ZERO;
			mic_r_s1 <= frame.mic_present ?
				frame.mic_right * $signed({1'b0, mic_gain}) : PROD_ZERO;
			sys_l_s1 <= frame.sys_present ?
				frame.sys_left * $signed({1'b0, sys_gain}) : PROD_ZERO;
			sys_r_s1 <= frame.sys_present ?
				frame.sys_right * $signed({1'b0, sys_gain}) : PROD_ZERO;
			last_s1  <= frame.last_in_block;
		end
	end

	// Sum, take magnitude and test against the clip level
	always_comb begin
		sum_l = SUM_W'(mic_l_s1) + SUM_W'(sys_l_s1);
		sum_r = SUM_W'(mic_r_s1) + SUM_W'(sys_r_s1);
		mag_l = sum_l[SUM_W-1] ? SUM_W'(-sum_l) : SUM_W'(sum_l);
		mag_r = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
		q_data.xq_l   = sgm_pkg::XQ_W'(mag_l >> SHIFT);
		q_data.xq_r   = sgm_pkg::XQ_W'(mag_r >> SHIFT);
		q_data.clip_l = mag_l > CLIP_LIM;
		q_data.clip_r = mag_r > CLIP_LIM;
		q_data.neg_l  = sum_l[SUM_W-1];
		q_data.neg_r  = sum_r[SUM_W-1];
		q_data.last   = last_s1;
	end

endmodule
`default_nettype wire

FILE: rtl/core/sgm_queue.sv
// Short queue of classified frames between front and back.
`default_nettype none
module sgm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire sgm_pkg::job_t   wr_data,
	input  wire logic            rd,
	output sgm_pkg::job_t        rd_data,
	output sgm_pkg::qstat_t      stat
);
	sgm_pkg::job_t                    entry_q [sgm_pkg::QDEPTH];
	logic [sgm_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
	logic [sgm_pkg::QPTR_W:0]         count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (sgm_pkg::QPTR_W+1)'(sgm_pkg::QDEPTH));
	assign rd_data    = entry_q[rptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (sgm_pkg::QPTR_W+1)'(wr) - (sgm_pkg::QPTR_W+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sgm_back.sv
// Back end: per-channel soft clip through a shared radix-2 divider, peak meter, result register.
`default_nettype none
module sgm_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sgm_pkg::qstat_t   qstat,
	input  wire sgm_pkg::job_t     q_data,
	output logic                   q_pop,
	output sgm_pkg::out_t          result,
	output logic                   empty,
	input  wire logic              pop
);
	sgm_pkg::bstate_t                 state_q, state_d;
	sgm_pkg::job_t                    ent_q;
	logic                             ch_q;
	logic [sgm_pkg::X2_W-1:0]         x2_q;
	logic [sgm_pkg::DEN_W-1:0]        den_q, rem_q, trial;
	logic [sgm_pkg::QUO_W-1:0]        qsh_q;
	logic [sgm_pkg::CNT_W-1:0]        cnt_q;
	logic [sgm_pkg::PEAK_W-1:0]       mag_l_q, mag_r_q, mag;
	logic [sgm_pkg::PEAK_W-1:0]       run_l_q, run_r_q, comp_l_q, comp_r_q;
	logic [sgm_pkg::PEAK_W-1:0]       run_l_n, run_r_n;
	logic                             res_valid_q, res_free;
	sgm_pkg::out_t                    res_q;
	logic [sgm_pkg::XQ_W-1:0]         xq;
	logic [sgm_pkg::NUM_W-1:0]        num;
	logic [sgm_pkg::YQ_W-1:0]         yq;
	logic [sgm_pkg::YQ_W+14:0]        yscaled;
	logic                             last_step, clip;

	assign result   = res_q;
	assign empty    = !res_valid_q;
	assign res_free = !res_valid_q || pop;
	assign q_pop    = (state_q == sgm_pkg::ST_IDLE) && !qstat.empty;
	assign last_step = (cnt_q == sgm_pkg::CNT_W'(sgm_pkg::QUO_W - 1));

	// Channel operand, numerator, divider step and output scaling
	always_comb begin
		xq    = ch_q ? ent_q.xq_r : ent_q.xq_l;
		clip  = ch_q ? ent_q.clip_r : ent_q.clip_l;
		num   = sgm_pkg::NUM_W'(xq) *
			sgm_pkg::NUM_W'(sgm_pkg::K27 + sgm_pkg::DEN_W'(x2_q));
		trial = {rem_q[sgm_pkg::DEN_W-2:0], qsh_q[sgm_pkg::QUO_W-1]};
		yq    = (qsh_q > sgm_pkg::QUO_W'(sgm_pkg::YQ_ONE)) ?
			sgm_pkg::YQ_ONE : sgm_pkg::YQ_W'(qsh_q);
		yscaled = {yq, 15'b0} - (sgm_pkg::YQ_W+15)'(yq);
		mag   = clip ? sgm_pkg::MAG_MAX : yscaled[38:24];
		run_l_n = (mag_l_q > run_l_q) ? mag_l_q : run_l_q;
		run_r_n = (mag_r_q > run_r_q) ? mag_r_q : run_r_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sgm_pkg::ST_IDLE:  if (!qstat.empty) state_d = sgm_pkg::ST_SQR;
			sgm_pkg::ST_SQR:   state_d = sgm_pkg::ST_NUM;
			sgm_pkg::ST_NUM:   state_d = sgm_pkg::ST_DIV;
			sgm_pkg::ST_DIV:   if (last_step) state_d = sgm_pkg::ST_SCALE;
			sgm_pkg::ST_SCALE: state_d = ch_q ? sgm_pkg::ST_FIN : sgm_pkg::ST_SQR;
			sgm_pkg::ST_FIN:   if (res_free) state_d = sgm_pkg::ST_IDLE;
			default:           state_d = sgm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and peak state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			run_l_q     <= '0;
			run_r_q     <= '0;
			comp_l_q    <= '0;
			comp_r_q    <= '0;
		end else begin
			if ((state_q == sgm_pkg::ST_FIN) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				sgm_pkg::ST_IDLE: begin
					ch_q <= 1'b0;
				end
				sgm_pkg::ST_NUM: begin
					cnt_q <= '0;
				end
				sgm_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
				end
				sgm_pkg::ST_SCALE: begin
					ch_q <= 1'b1;
				end
				sgm_pkg::ST_FIN: begin
					if (res_free) begin
						if (ent_q.last) begin
							comp_l_q <= run_l_n;
							comp_r_q <= run_r_n;
							run_l_q  <= '0;
							run_r_q  <= '0;
						end else begin
							run_l_q <= run_l_n;
							run_r_q <= run_r_n;
						end
					end
				end
				default: begin
					ch_q <= ch_q;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sgm_pkg::ST_IDLE: begin
				if (!qstat.empty) begin
					ent_q <= q_data;
				end
			end
			sgm_pkg::ST_SQR: begin
				x2_q <= sgm_pkg::X2_W'(xq) * sgm_pkg::X2_W'(xq);
			end
			sgm_pkg::ST_NUM: begin
				den_q <= sgm_pkg::K27 + sgm_pkg::DEN_W'(x2_q) * sgm_pkg::DEN_W'(9);
				rem_q <= sgm_pkg::DEN_W'(num >> 18);
				qsh_q <= {num[17:0], 8'b0};
			end
			sgm_pkg::ST_DIV: begin
				if (trial >= den_q) begin
					rem_q <= trial - den_q;
					qsh_q <= {qsh_q[sgm_pkg::QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					qsh_q <= {qsh_q[sgm_pkg::QUO_W-2:0], 1'b0};
				end
			end
			sgm_pkg::ST_SCALE: begin
				if (ch_q) begin
					mag_r_q <= mag;
				end else begin
					mag_l_q <= mag;
				end
			end
			sgm_pkg::ST_FIN: begin
				if (res_free) begin
					res_q.out_left  <= ent_q.neg_l ? -$signed({1'b0, mag_l_q})
						: $signed({1'b0, mag_l_q});
					res_q.out_right <= ent_q.neg_r ? -$signed({1'b0, mag_r_q})
						: $signed({1'b0, mag_r_q});
					res_q.block_peak_left  <= ent_q.last ? run_l_n : comp_l_q;
					res_q.block_peak_right <= ent_q.last ? run_r_n : comp_r_q;
					res_q.frame_last       <= ent_q.last;
				end
			end
			default: begin
				x2_q <= x2_q;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/stereo_gain_mixer_soft_clip.sv
// Top level of the two-source stereo mixer with rational-tanh soft clip and block peak meter.
//
// Input channel: present a frame on 'frame' with push; it is taken at a rising edge
// with push high and full low. Result channel: while empty is low the oldest result
// sits on 'result'; pop takes it at a rising edge with pop high and empty low.
// Configuration: APB-style writes, mic_gain at byte address 0, sys_gain at 4; write
// gains only while no frame is in flight.
// Path from the accepting edge to the result: the gain/sum stage register, the queue,
// then in the back end the load from the queue, per channel a square, a numerator,
// 26 divider steps and a scale, and the result write once the result slot is free.
// The back end takes one frame at a time through the one-bit-per-cycle divider shared by
// both channels; the front stage and a two-entry queue keep accepting up to three frames ahead of it.
// Reset: gains return to unity (32768), running and completed peaks clear, all
// queues empty. When the receiver stalls the result holds, the back end finishes the
// next frame and waits, and full rises once the queue and front stage are occupied.
`default_nettype none
module stereo_gain_mixer_soft_clip #(
	parameter int GAIN_FRAC_BITS = sgm_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sgm_pkg::in_t  frame,
	input  wire logic          push,
	output logic               full,
	output sgm_pkg::out_t      result,
	output logic               empty,
	input  wire logic          pop,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [sgm_pkg::GAIN_W-1:0] mic_gain_q, sys_gain_q;
	sgm_pkg::qstat_t            qstat;
	sgm_pkg::job_t              wr_job, rd_job;
	logic                       q_push, q_pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == sgm_pkg::REG_SYS_GAIN) ? 32'(sys_gain_q) : 32'(mic_gain_q);

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mic_gain_q <= sgm_pkg::GAIN_RESET;
			sys_gain_q <= sgm_pkg::GAIN_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == sgm_pkg::REG_MIC_GAIN) begin
				mic_gain_q <= pwdata[sgm_pkg::GAIN_W-1:0];
			end else begin
				sys_gain_q <= pwdata[sgm_pkg::GAIN_W-1:0];
			end
		end
	end

	sgm_front #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.push     (push),
		.full     (full),
		.mic_gain (mic_gain_q),
		.sys_gain (sys_gain_q),
		.qstat    (qstat),
		.q_push   (q_push),
		.q_data   (wr_job)
	);

	sgm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (wr_job),
		.rd      (q_pop),
		.rd_data (rd_job),
		.stat    (qstat)
	);

	sgm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.q_data (rd_job),
		.q_pop  (q_pop),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule
`default_nettype wire

FILE: rtl/core/sgm_checker.sv
// Port-level checker of the mixer and its bind to the top level.
`default_nettype none
module sgm_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          full,
	input wire sgm_pkg::out_t result,
	input wire logic          empty,
	input wire logic          pop
);
	logic [15:0] abs_l, abs_r;

	assign abs_l = result.out_left[15] ? 16'(-result.out_left) : 16'(result.out_left);
	assign abs_r = result.out_right[15] ? 16'(-result.out_right) : 16'(result.out_right);

	// Hold a waiting result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	// Output never reaches the most negative code
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.out_left != 16'h8000 && result.out_right != 16'h8000)
		else $error("output outside soft clip range");

	// Block end shows a peak at least as large as its own frame
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_last |->
			{1'b0, result.block_peak_left} >= abs_l &&
			{1'b0, result.block_peak_right} >= abs_r)
		else $error("block peak below final frame");

	// No result is present, and input is open, right after reset
	a_reset: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("result present or input blocked right after reset");

endmodule

bind stereo_gain_mixer_soft_clip sgm_checker u_sgm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.result (result),
	.empty  (empty),
	.pop    (pop)
);
`default_nettype wire
